// ===== rtl/yenc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the yEnc line encoder: character codes, the queue entry type,
// the back end step type and the CRC-32 byte update. No dependencies.
package yenc_pkg;

  localparam logic [7:0] LineLimitReset = 8'd128;
  localparam logic [7:0] EncOffset      = 8'd42;
  localparam logic [7:0] EscOffset      = 8'd64;
  localparam logic [7:0] CountMax       = 8'd255;

  localparam logic [7:0] ChrNul = 8'h00;
  localparam logic [7:0] ChrTab = 8'h09;
  localparam logic [7:0] ChrLf  = 8'h0A;
  localparam logic [7:0] ChrCr  = 8'h0D;
  localparam logic [7:0] ChrEsc = 8'h1B;
  localparam logic [7:0] ChrDot = 8'h2E;
  localparam logic [7:0] ChrEq  = 8'h3D;

  localparam logic [31:0] CrcPoly = 32'hEDB88320;

  localparam int unsigned FifoDepthDefault = 4;

  typedef struct packed {
    logic        lf;
    logic        esc;
    logic [7:0]  data;
    logic [31:0] crc;
  } entry_t;

  typedef enum logic [1:0] {
    STEP_NEW,
    STEP_ESC,
    STEP_DATA
  } step_e;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return ~c;
  endfunction

endpackage

// ===== rtl/yenc_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the yEnc line encoder: one raw byte per request.
// No dependencies.
interface yenc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source(output valid, output data_byte, output end_of_data, input ready);
  modport sink(input valid, input data_byte, input end_of_data, output ready);
endinterface

// ===== rtl/yenc_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the yEnc line encoder: one encoded byte per request.
// No dependencies.
interface yenc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        run_last;
  logic [31:0] crc_value;

  modport source(output valid, output out_byte, output run_last, output crc_value,
                 input ready);
  modport sink(input valid, input out_byte, input run_last, input crc_value,
               output ready);
endinterface

// ===== rtl/yenc_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts raw bytes, updates CRC and line count, classifies bytes.
// Depends on yenc_pkg and yenc_in_if.
module yenc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  yenc_in_if.sink           in_i,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              full_i,
  output logic              push_o,
  output yenc_pkg::entry_t  entry_o
);

  logic [7:0]  limit_q, limit_d;
  logic [7:0]  count_q, count_d;
  logic [31:0] crc_q, crc_d;

  logic [7:0]  enc;
  logic [31:0] crc_next;
  logic        lf;
  logic [7:0]  cnt_base;
  logic        esc;
  logic [8:0]  cnt_sum;
  logic [7:0]  cnt_sat;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    enc      = in_i.data_byte + yenc_pkg::EncOffset;
    crc_next = yenc_pkg::crc_byte(crc_q, in_i.data_byte);
    lf       = count_q >= limit_q;
    cnt_base = lf ? 8'd0 : count_q;
    esc      = (enc == yenc_pkg::ChrNul) || (enc == yenc_pkg::ChrTab) ||
               (enc == yenc_pkg::ChrLf) || (enc == yenc_pkg::ChrCr) ||
               (enc == yenc_pkg::ChrEq) || (enc == yenc_pkg::ChrEsc) ||
               ((enc == yenc_pkg::ChrDot) && (cnt_base == 8'd0));
    cnt_sum  = {1'b0, cnt_base} + (esc ? 9'd2 : 9'd1);
    cnt_sat  = cnt_sum[8] ? yenc_pkg::CountMax : cnt_sum[7:0];
  end

  always_comb begin
    entry_o.lf   = lf;
    entry_o.esc  = esc;
    entry_o.data = esc ? (enc + yenc_pkg::EscOffset) : enc;
    entry_o.crc  = crc_next;
  end

  always_comb begin
    limit_d = cfg_we_i ? cfg_data_i : limit_q;
    count_d = count_q;
    crc_d   = crc_q;
    if (push_o) begin
      count_d = in_i.end_of_data ? 8'd0 : cnt_sat;
      crc_d   = in_i.end_of_data ? 32'd0 : crc_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= yenc_pkg::LineLimitReset;
      count_q <= 8'd0;
      crc_q   <= 32'd0;
    end else begin
      limit_q <= limit_d;
      count_q <= count_d;
      crc_q   <= crc_d;
    end
  end

endmodule

// ===== rtl/yenc_fifo.sv =====
`timescale 1ns / 1ps
// Short queue of classified bytes between the front and back ends.
// Depends on yenc_pkg.
module yenc_fifo #(
  parameter int unsigned Depth = yenc_pkg::FifoDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  yenc_pkg::entry_t  entry_i,
  input  logic              pop_i,
  output yenc_pkg::entry_t  head_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  yenc_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== rtl/yenc_back.sv =====
`timescale 1ns / 1ps
// Back end: expands each queued entry into LF, escape and data bytes.
// Depends on yenc_pkg and yenc_out_if.
module yenc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  yenc_pkg::entry_t  head_i,
  output logic              pop_o,
  yenc_out_if.source        out_o
);

  yenc_pkg::step_e step_q, step_d;
  yenc_pkg::step_e cur;

  logic        valid_q, valid_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic [31:0] crc_q, crc_d;
  logic        fire;

  assign fire  = (!valid_q || out_o.ready) && !empty_i;
  assign pop_o = fire && (cur == yenc_pkg::STEP_DATA);

  always_comb begin
    cur = step_q;
    if (step_q == yenc_pkg::STEP_NEW) begin
      if (head_i.lf) begin
        cur = yenc_pkg::STEP_NEW;
      end else if (head_i.esc) begin
        cur = yenc_pkg::STEP_ESC;
      end else begin
        cur = yenc_pkg::STEP_DATA;
      end
    end
  end

  // Next step within the current entry.
  always_comb begin
    step_d = step_q;
    if (fire) begin
      unique case (cur)
        yenc_pkg::STEP_NEW:  step_d = head_i.esc ? yenc_pkg::STEP_ESC : yenc_pkg::STEP_DATA;
        yenc_pkg::STEP_ESC:  step_d = yenc_pkg::STEP_DATA;
        yenc_pkg::STEP_DATA: step_d = yenc_pkg::STEP_NEW;
        default:             step_d = yenc_pkg::STEP_NEW;
      endcase
    end
  end

  // Output register; a NEW step here means the inserted line feed.
  always_comb begin
    valid_d = out_o.ready ? 1'b0 : valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    crc_d   = crc_q;
    if (fire) begin
      valid_d = 1'b1;
      crc_d   = head_i.crc;
      unique case (cur)
        yenc_pkg::STEP_NEW: begin
          byte_d = yenc_pkg::ChrLf;
          last_d = 1'b0;
        end
        yenc_pkg::STEP_ESC: begin
          byte_d = yenc_pkg::ChrEq;
          last_d = 1'b0;
        end
        yenc_pkg::STEP_DATA: begin
          byte_d = head_i.data;
          last_d = 1'b1;
        end
        default: begin
          byte_d = head_i.data;
          last_d = 1'b1;
        end
      endcase
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.out_byte  = byte_q;
  assign out_o.run_last  = last_q;
  assign out_o.crc_value = crc_q;

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    crc_q  <= crc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= yenc_pkg::STEP_NEW;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

endmodule

// ===== rtl/yenc_line_encoder_crc_core.sv =====
`timescale 1ns / 1ps
// yEnc line encoder with running CRC-32, top level.
// Depends on yenc_pkg, yenc_in_if, yenc_out_if, yenc_front, yenc_fifo, yenc_back.
//
// The block takes one raw byte per cycle while the queue has room and emits
// one encoded byte per cycle while the output is ready; an input byte produces
// one to three output bytes (line feed, escape, data), so input is accepted
// every cycle as long as the queue between the front and back ends has room,
// and the output byte rate of the back end is the limit. The user must see that
// the line limit is written through cfg_we_i and cfg_data_i only while the block
// is idle; the block does not enforce this. The line limit resets to 128.
module yenc_line_encoder_crc_core #(
  parameter int unsigned FifoDepth = yenc_pkg::FifoDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  yenc_in_if.sink     in_i,
  yenc_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i
);

  yenc_pkg::entry_t push_entry;
  yenc_pkg::entry_t head;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;

  yenc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  yenc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  yenc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== bench/tb_yenc_line_encoder_crc_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for yenc_line_encoder_crc_core: directed and random byte streams
// against an in-bench encoder and CRC-32 predictor, with random idling on both channels.
// Depends on yenc_pkg, yenc_in_if, yenc_out_if and the core itself.
module tb_yenc_line_encoder_crc_core;

  localparam logic [7:0] KeepLimit = 8'd0;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned DrainCycles = 4;

  localparam logic [7:0] RawNul = yenc_pkg::ChrNul - yenc_pkg::EncOffset;
  localparam logic [7:0] RawTab = yenc_pkg::ChrTab - yenc_pkg::EncOffset;
  localparam logic [7:0] RawLf  = yenc_pkg::ChrLf - yenc_pkg::EncOffset;
  localparam logic [7:0] RawCr  = yenc_pkg::ChrCr - yenc_pkg::EncOffset;
  localparam logic [7:0] RawEsc = yenc_pkg::ChrEsc - yenc_pkg::EncOffset;
  localparam logic [7:0] RawEq  = yenc_pkg::ChrEq - yenc_pkg::EncOffset;
  localparam logic [7:0] RawDot = yenc_pkg::ChrDot - yenc_pkg::EncOffset;

  typedef enum logic {
    ROW_PREDICT,
    ROW_TYPED
  } row_e;

  typedef struct packed {
    logic [7:0]  limit_w;
    logic [7:0]  data;
    logic        eod;
    row_e        kind;
    logic [7:0]  exp_byte;
    logic [31:0] exp_crc;
  } stim_row_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        run_last;
    logic [31:0] crc_value;
  } enc_result_t;

  localparam int NumDirRows = 20;
  localparam stim_row_t DirRows [NumDirRows] = '{
    '{KeepLimit, 8'h00, 1'b1, ROW_TYPED, 8'h2A, 32'hD202EF8D},
    '{KeepLimit, 8'hFF, 1'b1, ROW_TYPED, 8'h29, 32'hFF000000},
    '{KeepLimit, RawDot, 1'b0, ROW_PREDICT, 8'h00, 32'h0},
    '{KeepLimit, RawDot, 1'b0, ROW_PREDICT, 8'h00, 32'h0},
    '{KeepLimit, RawNul, 1'b0, ROW_PREDICT, 8'h00, 32'h0},
    '{KeepLimit, RawTab, 1'b0, ROW_PREDICT, 8'h00, 32'h0},
    '{KeepLimit, RawLf, 1'b0, ROW_PREDICT, 8'h00, 32'h0},
    '{KeepLimit, RawCr, 1'b0, ROW_PREDICT, 8'h00, 32'h0},
    '{KeepLimit, RawEsc, 1'b0, ROW_PREDICT, 8'h00, 32'h0},
    '{KeepLimit, RawEq, 1'b0, ROW_PREDICT, 8'h00, 32'h0},
    '{KeepLimit, 8'hD5, 1'b0, ROW_PREDICT, 8'h00, 32'h0},
    '{KeepLimit, 8'h80, 1'b1, ROW_PREDICT, 8'h00, 32'h0},
    '{8'd1, RawDot, 1'b0, ROW_PREDICT, 8'h00, 32'h0},
    '{KeepLimit, RawNul, 1'b0, ROW_PREDICT, 8'h00, 32'h0},
    '{KeepLimit, RawDot, 1'b0, ROW_PREDICT, 8'h00, 32'h0},
    '{KeepLimit, 8'h55, 1'b1, ROW_PREDICT, 8'h00, 32'h0},
    '{KeepLimit, RawLf, 1'b1, ROW_PREDICT, 8'h00, 32'h0},
    '{KeepLimit, 8'h7F, 1'b0, ROW_PREDICT, 8'h00, 32'h0},
    '{KeepLimit, RawCr, 1'b1, ROW_PREDICT, 8'h00, 32'h0},
    '{8'd254, RawTab, 1'b1, ROW_PREDICT, 8'h00, 32'h0}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_data_i;

  yenc_in_if  in_ch ();
  yenc_out_if out_ch ();

  yenc_line_encoder_crc_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  enc_result_t encoded_q [$];
  logic [7:0]  wrap_limit;
  int          line_fill;
  logic [31:0] data_crc;
  bit          tx_idle;
  bit          rx_idle;
  bit          hold_req;
  int          n_errors;
  int          n_sent;
  int          n_checked;
  int          n_lf;
  int          n_esc;
  int          n_limits;

  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    r = ~crc;
    r[7:0] = r[7:0] ^ b;
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (r[0] ? yenc_pkg::CrcPoly : 32'h0);
    end
    return ~r;
  endfunction

  function automatic void push_encoded(input logic [7:0] b, input logic last);
    enc_result_t r;
    r.out_byte = b;
    r.run_last = last;
    r.crc_value = data_crc;
    encoded_q.push_back(r);
  endfunction

  function automatic void encode_byte(input logic [7:0] raw, input logic eod);
    logic [7:0] enc;
    logic       esc;
    data_crc = crc32_update(data_crc, raw);
    if (line_fill >= int'(wrap_limit)) begin
      push_encoded(yenc_pkg::ChrLf, 1'b0);
      line_fill = 0;
      n_lf++;
    end
    enc = raw + yenc_pkg::EncOffset;
    esc = (enc == yenc_pkg::ChrNul) || (enc == yenc_pkg::ChrTab) ||
          (enc == yenc_pkg::ChrLf) || (enc == yenc_pkg::ChrCr) ||
          (enc == yenc_pkg::ChrEq) || (enc == yenc_pkg::ChrEsc) ||
          (enc == yenc_pkg::ChrDot && line_fill == 0);
    if (esc) begin
      push_encoded(yenc_pkg::ChrEq, 1'b0);
      push_encoded(enc + yenc_pkg::EscOffset, 1'b1);
      line_fill = (line_fill + 2 > 255) ? 255 : line_fill + 2;
      n_esc++;
    end else begin
      push_encoded(enc, 1'b1);
      line_fill = (line_fill + 1 > 255) ? 255 : line_fill + 1;
    end
    if (eod) begin
      line_fill = 0;
      data_crc = 32'h0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    n_errors++;
  endtask

  task automatic check_encoded(input logic [7:0] b, input logic last, input logic [31:0] crc);
    enc_result_t want;
    if (encoded_q.size() == 0) begin
      report_mismatch("unexpected out_byte", {24'h0, b}, 32'h0);
    end else begin
      want = encoded_q.pop_front();
      n_checked++;
      if (b !== want.out_byte) report_mismatch("out_byte", {24'h0, b}, {24'h0, want.out_byte});
      if (last !== want.run_last) report_mismatch("run_last", {31'h0, last}, {31'h0, want.run_last});
      if (crc !== want.crc_value) report_mismatch("crc_value", crc, want.crc_value);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      check_encoded(out_ch.out_byte, out_ch.run_last, out_ch.crc_value);
    end
  end

  initial begin
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HoldCycles;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        stall = pick_gap(rx_idle);
      end
    end
  end

  task automatic send_request(input logic [7:0] d, input logic eod);
    int gap;
    gap = pick_gap(tx_idle);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= d;
    in_ch.end_of_data <= eod;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic wait_drained();
    while (encoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [7:0] v);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    wrap_limit = v;
    n_limits++;
  endtask

  function automatic logic [7:0] pick_byte(input int esc_pct);
    logic [7:0] picks [7];
    picks = '{RawNul, RawTab, RawLf, RawCr, RawEsc, RawEq, RawDot};
    if ($urandom_range(0, 99) < esc_pct) return picks[$urandom_range(0, 6)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic run_phase(input int count, input int esc_pct, input int eod_odds,
                           input bit eod_at_end);
    logic [7:0] d;
    logic       eod;
    for (int i = 0; i < count; i++) begin
      d = pick_byte(esc_pct);
      eod = (eod_odds > 0 && $urandom_range(1, eod_odds) == 1) ||
            (eod_at_end && i == count - 1);
      send_request(d, eod);
      encode_byte(d, eod);
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    int mark;
    stim_row_t row;
    enc_result_t typed;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_data_i <= 8'h0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= 8'h0;
    in_ch.end_of_data <= 1'b0;
    wrap_limit = yenc_pkg::LineLimitReset;
    line_fill = 0;
    data_crc = 32'h0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_req = 1'b0;
    n_errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_lf = 0;
    n_esc = 0;
    n_limits = 1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirRows; i++) begin
      row = DirRows[i];
      if (row.limit_w != KeepLimit) begin
        in_ch.valid <= 1'b0;
        wait_drained();
        set_limit(row.limit_w);
      end
      send_request(row.data, row.eod);
      mark = encoded_q.size();
      encode_byte(row.data, row.eod);
      if (row.kind == ROW_TYPED) begin
        while (encoded_q.size() > mark) void'(encoded_q.pop_back());
        typed.out_byte = row.exp_byte;
        typed.run_last = 1'b1;
        typed.crc_value = row.exp_crc;
        encoded_q.push_back(typed);
      end
    end
    in_ch.valid <= 1'b0;
    wait_drained();

    set_limit(8'd1);
    run_phase(30, 30, 16, 1'b0);
    wait_drained();

    tx_idle = 1'b0;
    rx_idle = 1'b0;
    set_limit(8'd254);
    run_phase(30, 90, 0, 1'b1);
    wait_drained();

    set_limit(8'd2);
    hold_req = 1'b1;
    run_phase(20, 30, 8, 1'b0);
    wait_drained();

    for (int p = 0; p < 3; p++) begin
      tx_idle = (p != 1);
      rx_idle = (p != 2);
      set_limit(8'($urandom_range(1, 254)));
      run_phase(20, 20, 10, 1'b0);
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    $display("Sent %0d raw bytes under %0d line limits and checked %0d encoded bytes,",
             n_sent, n_limits, n_checked);
    $display("including %0d escape pairs and %0d inserted line feeds.", n_esc, n_lf);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/yenc_pkg.sv
rtl/yenc_in_if.sv
rtl/yenc_out_if.sv
rtl/yenc_front.sv
rtl/yenc_fifo.sv
rtl/yenc_back.sv
rtl/yenc_line_encoder_crc_core.sv
bench/tb_yenc_line_encoder_crc_core.sv
